// ===== rtl/scfd_pkg.sv =====
// Shared types and constants for the serial command frame decoder.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package scfd_pkg;

	localparam int unsigned MAX_LEN     = 32;
	localparam int unsigned CNT_W       = $clog2(MAX_LEN + 1);
	localparam int unsigned FRAME_LEN_W = 6;
	localparam int unsigned CMD_BYTES   = 3;
	localparam int unsigned CMD_FIRST   = 3;

	localparam logic [7:0] END_BYTE_RESET = 8'h0A;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_THREE = 8'h33;
	localparam logic [7:0] CH_SIX   = 8'h36;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_T     = 8'h54;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_WANT_ONE,
		PH_WANT_SIX,
		PH_BODY
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_LED,
		KIND_SWITCH,
		KIND_ACCEL
	} cmd_kind_t;

	typedef enum logic [1:0] {
		LED_ON,
		LED_OFF,
		LED_TOGGLE,
		LED_UNUSED
	} led_action_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic        led_sel;
		led_action_t led_act;
		logic        sw_sel;
		logic        respond;
	} cmd_result_t;

endpackage

`default_nettype wire

// ===== rtl/serial_command_frame_decoder_core.sv =====
// Output: a result is registered and appears in the cycle after its end byte is accepted.
// Throughput: one byte per cycle; a byte is taken whenever the output register is
// empty or is being drained in the same cycle.
// Reset: asynchronous, active low; clears the frame state and output valid, and sets
// the end byte to newline.
// Top level of the serial command frame decoder; uses scfd_pkg and scfd_cmd_decode.
`default_nettype none

module serial_command_frame_decoder_core import scfd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [7:0]             cfg_wr_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             data_byte,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             command_kind,
	output logic                   led_select,
	output logic [1:0]             led_action,
	output logic                   switch_select,
	output logic                   respond,
	output logic [FRAME_LEN_W-1:0] frame_length
);

	logic [7:0]       end_byte_q;
	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [7:0]       cmd_q [CMD_BYTES];
	logic [7:0]       cmd_d [CMD_BYTES];
	logic             emit;
	logic             accept;
	logic             out_valid_q;
	logic [1:0]       cmd_off;
	logic             cmd_hit;
	cmd_result_t      dec;
	cmd_result_t      res_q;
	logic [FRAME_LEN_W-1:0] len_q;

	assign accept   = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;
	assign cmd_off  = 2'(cnt_q - CNT_W'(CMD_FIRST));
	assign cmd_hit  = (cnt_q >= CNT_W'(CMD_FIRST)) &&
		(cnt_q < CNT_W'(CMD_FIRST + CMD_BYTES));

	scfd_cmd_decode u_decode (
		.cmd_byte0 (cmd_q[0]),
		.cmd_byte1 (cmd_q[1]),
		.cmd_byte2 (cmd_q[2]),
		.result    (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_byte_q <= END_BYTE_RESET;
		end else if (cfg_wr_en) begin
			end_byte_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			for (int i = 0; i < CMD_BYTES; i++) begin
				cmd_q[i] <= '0;
			end
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			cmd_q   <= cmd_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		cmd_d   = cmd_q;
		emit    = 1'b0;
		if (accept) begin
			case (phase_q)
				PH_WANT_ONE: begin
					if (data_byte == CH_ONE) begin
						cnt_d   = cnt_q + 1'b1;
						phase_d = PH_WANT_SIX;
					end else begin
						cnt_d   = '0;
						phase_d = PH_IDLE;
					end
				end
				PH_WANT_SIX: begin
					if (data_byte == CH_SIX) begin
						cnt_d   = cnt_q + 1'b1;
						phase_d = PH_BODY;
					end else begin
						cnt_d   = '0;
						phase_d = PH_IDLE;
					end
				end
				PH_BODY: begin
					if (cnt_q >= CNT_W'(MAX_LEN)) begin
						cnt_d   = '0;
						phase_d = PH_IDLE;
						if (data_byte == CH_COLON) begin
							cnt_d   = CNT_W'(1);
							cmd_d   = '{default: '0};
							phase_d = PH_WANT_ONE;
						end
					end else if (data_byte == CH_COLON) begin
						cnt_d   = CNT_W'(1);
						cmd_d   = '{default: '0};
						phase_d = PH_WANT_ONE;
					end else if (data_byte != end_byte_q) begin
						if (cmd_hit) begin
							cmd_d[cmd_off] = data_byte;
						end
						cnt_d = cnt_q + 1'b1;
					end else begin
						emit    = 1'b1;
						cnt_d   = '0;
						phase_d = PH_IDLE;
					end
				end
				default: begin
					if (data_byte == CH_COLON) begin
						cnt_d   = CNT_W'(1);
						cmd_d   = '{default: '0};
						phase_d = PH_WANT_ONE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= dec;
			len_q <= FRAME_LEN_W'(cnt_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign command_kind  = res_q.kind;
	assign led_select    = res_q.led_sel;
	assign led_action    = res_q.led_act;
	assign switch_select = res_q.sw_sel;
	assign respond       = res_q.respond;
	assign frame_length  = len_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_LEN))
		else $error("stored count exceeds the frame limit");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (cnt_q == '0))
		else $error("idle phase with stored bytes");

	a_body_header: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY) |-> (cnt_q >= CNT_W'(CMD_FIRST)))
		else $error("frame body without a full header");

	a_emit_end: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (out_valid && (phase_q == PH_IDLE) && (respond == (command_kind != KIND_NONE))))
		else $error("closed frame did not produce a consistent result");

endmodule

`default_nettype wire

// ===== rtl/scfd_cmd_decode.sv =====
// Decodes the three stored command bytes of a frame into a command result.
// Depends on scfd_pkg for the character codes and the result struct.
`default_nettype none

module scfd_cmd_decode import scfd_pkg::*; (
	input  logic [7:0]  cmd_byte0,
	input  logic [7:0]  cmd_byte1,
	input  logic [7:0]  cmd_byte2,
	output cmd_result_t result
);

	logic sel_ok;
	logic act_ok;

	assign sel_ok = (cmd_byte1 == CH_ONE) || (cmd_byte1 == CH_TWO);
	assign act_ok = (cmd_byte2 == CH_E) || (cmd_byte2 == CH_A) || (cmd_byte2 == CH_T);

	always_comb begin
		result = '{kind: KIND_NONE, led_sel: 1'b0, led_act: LED_ON, sw_sel: 1'b0,
			respond: 1'b0};
		if (cmd_byte0 == CH_ZERO) begin
			if (sel_ok && act_ok) begin
				result.kind    = KIND_LED;
				result.led_sel = (cmd_byte1 == CH_TWO);
				if (cmd_byte2 == CH_E) begin
					result.led_act = LED_ON;
				end else if (cmd_byte2 == CH_A) begin
					result.led_act = LED_OFF;
				end else begin
					result.led_act = LED_TOGGLE;
				end
			end
		end else if (cmd_byte0 == CH_ONE) begin
			if ((cmd_byte1 == CH_ONE) || (cmd_byte1 == CH_THREE)) begin
				result.kind   = KIND_SWITCH;
				result.sw_sel = (cmd_byte1 == CH_THREE);
			end
		end else if (cmd_byte0 == CH_TWO) begin
			if (cmd_byte1 == CH_ZERO) begin
				result.kind = KIND_ACCEL;
			end
		end
		result.respond = (result.kind != KIND_NONE);
	end

endmodule

`default_nettype wire

// ===== tb/scfd_tb_pkg.sv =====
// Scoreboard for the serial command frame decoder testbench.
// It predicts the frame results from the accepted bytes and checks the block's output.
// Depends on scfd_pkg for the phase, command and character constants.
package scfd_tb_pkg;

	import scfd_pkg::*;

	typedef struct packed {
		cmd_result_t                cmd;
		logic [FRAME_LEN_W-1:0]     len;
	} frame_result_t;

	class frame_decode_scoreboard;

		logic [7:0]      end_char;
		phase_t          phase;
		int unsigned     stored;
		logic [7:0]      cmd_bytes [CMD_BYTES];
		frame_result_t   awaited_frames [$];
		int unsigned     errors;

		function new();
			end_char = END_BYTE_RESET;
			phase = PH_IDLE;
			stored = 0;
			errors = 0;
			foreach (cmd_bytes[i]) cmd_bytes[i] = 8'h00;
		endfunction

		function void set_end_byte(logic [7:0] v);
			end_char = v;
		endfunction

		function int unsigned awaited();
			return awaited_frames.size();
		endfunction

		function void open_frame();
			stored = 1;
			foreach (cmd_bytes[i]) cmd_bytes[i] = 8'h00;
			phase = PH_WANT_ONE;
		endfunction

		function void keep_byte(logic [7:0] b);
			if (stored >= CMD_FIRST && stored < CMD_FIRST + CMD_BYTES) begin
				cmd_bytes[stored - CMD_FIRST] = b;
			end
			stored++;
		endfunction

		function logic [7:0] frame_byte(int unsigned idx);
			if (idx >= stored) begin
				return 8'h00;
			end
			return cmd_bytes[idx - CMD_FIRST];
		endfunction

		function frame_result_t decode_frame();
			frame_result_t r;
			logic [7:0] b3, b4, b5;
			b3 = frame_byte(3);
			b4 = frame_byte(4);
			b5 = frame_byte(5);
			r = '0;
			r.cmd.kind = KIND_NONE;
			r.cmd.led_act = LED_ON;
			if (b3 == CH_ZERO) begin
				if ((b4 == CH_ONE || b4 == CH_TWO) && (b5 == CH_E || b5 == CH_A || b5 == CH_T)) begin
					r.cmd.kind = KIND_LED;
					r.cmd.led_sel = (b4 == CH_TWO);
					if (b5 == CH_E) begin
						r.cmd.led_act = LED_ON;
					end else if (b5 == CH_A) begin
						r.cmd.led_act = LED_OFF;
					end else begin
						r.cmd.led_act = LED_TOGGLE;
					end
				end
			end else if (b3 == CH_ONE) begin
				if (b4 == CH_ONE || b4 == CH_THREE) begin
					r.cmd.kind = KIND_SWITCH;
					r.cmd.sw_sel = (b4 == CH_THREE);
				end
			end else if (b3 == CH_TWO) begin
				if (b4 == CH_ZERO) begin
					r.cmd.kind = KIND_ACCEL;
				end
			end
			r.cmd.respond = (r.cmd.kind != KIND_NONE);
			r.len = stored[FRAME_LEN_W-1:0];
			return r;
		endfunction

		function void note_byte(logic [7:0] b);
			case (phase)
				PH_WANT_ONE: begin
					if (b == CH_ONE) begin
						keep_byte(b);
						phase = PH_WANT_SIX;
					end else begin
						stored = 0;
						phase = PH_IDLE;
					end
				end
				PH_WANT_SIX: begin
					if (b == CH_SIX) begin
						keep_byte(b);
						phase = PH_BODY;
					end else begin
						stored = 0;
						phase = PH_IDLE;
					end
				end
				PH_BODY: begin
					if (stored >= MAX_LEN) begin
						stored = 0;
						phase = PH_IDLE;
						if (b == CH_COLON) open_frame();
					end else if (b == CH_COLON) begin
						open_frame();
					end else if (b != end_char) begin
						keep_byte(b);
					end else begin
						awaited_frames.push_back(decode_frame());
						stored = 0;
						phase = PH_IDLE;
					end
				end
				default: begin
					if (b == CH_COLON) open_frame();
				end
			endcase
		endfunction

		function void check_frame(logic [1:0] kind, logic lsel, logic [1:0] lact, logic ssel,
				logic resp, logic [FRAME_LEN_W-1:0] flen);
			frame_result_t w;
			if (awaited_frames.size() == 0) begin
				$error("command_kind: no result expected, got %0d", kind);
				errors++;
				return;
			end
			w = awaited_frames.pop_front();
			if (kind !== w.cmd.kind) begin
				$error("command_kind: expected %0d, actual %0d", w.cmd.kind, kind);
				errors++;
			end
			if (lsel !== w.cmd.led_sel) begin
				$error("led_select: expected %0d, actual %0d", w.cmd.led_sel, lsel);
				errors++;
			end
			if (lact !== w.cmd.led_act) begin
				$error("led_action: expected %0d, actual %0d", w.cmd.led_act, lact);
				errors++;
			end
			if (ssel !== w.cmd.sw_sel) begin
				$error("switch_select: expected %0d, actual %0d", w.cmd.sw_sel, ssel);
				errors++;
			end
			if (resp !== w.cmd.respond) begin
				$error("respond: expected %0d, actual %0d", w.cmd.respond, resp);
				errors++;
			end
			if (flen !== w.len) begin
				$error("frame_length: expected %0d, actual %0d", w.len, flen);
				errors++;
			end
		endfunction

	endclass

endpackage

// ===== tb/tb_serial_command_frame_decoder_core.sv =====
// Top-level testbench for serial_command_frame_decoder_core.
// Sends directed and random byte streams under several end bytes with random stalls.
// Depends on scfd_pkg and the scoreboard in scfd_tb_pkg.
module tb_serial_command_frame_decoder_core;

	timeunit 1ns;
	timeprecision 1ps;

	import scfd_pkg::*;
	import scfd_tb_pkg::*;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [7:0]             cfg_wr_data = 8'h00;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [7:0]             data_byte = 8'h00;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [1:0]             command_kind;
	logic                   led_select;
	logic [1:0]             led_action;
	logic                   switch_select;
	logic                   respond;
	logic [FRAME_LEN_W-1:0] frame_length;

	frame_decode_scoreboard sb = new();

	logic [7:0]  tx_bytes [$];
	logic [7:0]  end_sel = END_BYTE_RESET;
	int unsigned burst_left = 0;
	int unsigned counted = 0;

	serial_command_frame_decoder_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.command_kind  (command_kind),
		.led_select    (led_select),
		.led_action    (led_action),
		.switch_select (switch_select),
		.respond       (respond),
		.frame_length  (frame_length)
	);

	always #1 clk = ~clk;

	// Every accepted beat on either side goes to the scoreboard.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			sb.check_frame(command_kind, led_select, led_action, switch_select, respond,
				frame_length);
		end
		if (in_valid && in_ready) begin
			sb.note_byte(data_byte);
		end
	end

	task automatic send_byte(logic [7:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_queued();
		while (tx_bytes.size() != 0) begin
			send_byte(tx_bytes.pop_front());
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.awaited() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_end_byte(logic [7:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_end_byte(v);
		end_sel = v;
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			tx_bytes.push_back(s[i]);
		end
	endtask

	function automatic logic [7:0] pick_body_byte();
		logic [7:0] v;
		v = 8'($urandom_range(0, 255));
		while (v == end_sel || v == CH_COLON) v = 8'($urandom_range(0, 255));
		return v;
	endfunction

	task automatic push_command();
		logic [7:0] c [3];
		case ($urandom_range(0, 3))
			0: begin
				c[0] = CH_ZERO;
				c[1] = $urandom_range(0, 1) ? CH_TWO : CH_ONE;
				case ($urandom_range(0, 2))
					0: c[2] = CH_E;
					1: c[2] = CH_A;
					default: c[2] = CH_T;
				endcase
			end
			1: begin
				c[0] = CH_ONE;
				c[1] = $urandom_range(0, 1) ? CH_THREE : CH_ONE;
				c[2] = pick_body_byte();
			end
			2: begin
				c[0] = CH_TWO;
				c[1] = CH_ZERO;
				c[2] = pick_body_byte();
			end
			default: begin
				foreach (c[i]) c[i] = pick_body_byte();
			end
		endcase
		if ($urandom_range(0, 4) == 0) c[$urandom_range(0, 2)] = pick_body_byte();
		foreach (c[i]) tx_bytes.push_back(c[i]);
	endtask

	task automatic push_header();
		tx_bytes.push_back(CH_COLON);
		tx_bytes.push_back(CH_ONE);
		tx_bytes.push_back(CH_SIX);
	endtask

	task automatic queue_random_sequence();
		int unsigned r, n;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			if (r >= 64) begin
				push_header();
				repeat ($urandom_range(0, 4)) tx_bytes.push_back(pick_body_byte());
			end
			push_header();
			push_command();
			n = ($urandom_range(0, 24) == 0) ? $urandom_range(24, 34) : $urandom_range(0, 3);
			repeat (n) tx_bytes.push_back(pick_body_byte());
			tx_bytes.push_back(end_sel);
		end else if (r < 80) begin
			push_header();
			repeat ($urandom_range(0, 2)) tx_bytes.push_back(pick_body_byte());
			tx_bytes.push_back(end_sel);
		end else if (r < 90) begin
			tx_bytes.push_back(CH_COLON);
			if ($urandom_range(0, 1)) tx_bytes.push_back(CH_ONE);
			tx_bytes.push_back($urandom_range(0, 3) == 0 ? CH_COLON : 8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 3)) tx_bytes.push_back(8'($urandom_range(0, 255)));
			tx_bytes.delete();
			repeat ($urandom_range(1, 3)) begin
				send_byte(8'($urandom_range(0, 255)));
			end
			return;
		end
		counted += tx_bytes.size();
		send_queued();
	endtask

	task automatic run_random_phase(int unsigned items);
		int unsigned stop_at;
		stop_at = counted + items;
		while (counted < stop_at) queue_random_sequence();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_text(":1602T\n");
		push_text(":1613\n");
		push_text(":16:1620\n");
		push_text(":1:");
		tx_bytes.push_back(8'hFF);
		tx_bytes.push_back(8'h00);
		push_text(":16\n");
		send_queued();

		run_random_phase(300);
		drain();
		write_end_byte(8'hFF);
		run_random_phase(300);
		drain();
		write_end_byte(8'h00);
		run_random_phase(300);
		drain();
		write_end_byte(CH_COLON);
		run_random_phase(80);
		drain();
		write_end_byte(8'h0D);
		run_random_phase(300);
		drain();
		write_end_byte(8'($urandom_range(0, 255)));
		run_random_phase(300);
		drain();

		if (sb.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		int unsigned seg, len, mode;
		seg = 0;
		@(posedge arst_n);
		forever begin
			seg++;
			if (seg % 10 == 0) begin
				len = $urandom_range(100, 200);
				repeat (len) begin
					@(posedge clk);
					out_ready <= 1'b0;
				end
			end else begin
				mode = $urandom_range(0, 2);
				len = $urandom_range(5, 40);
				repeat (len) begin
					@(posedge clk);
					case (mode)
						0: out_ready <= 1'b1;
						1: out_ready <= 1'($urandom_range(0, 1));
						default: out_ready <= ($urandom_range(0, 3) == 0);
					endcase
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/scfd_pkg.sv
rtl/scfd_cmd_decode.sv
rtl/serial_command_frame_decoder_core.sv
tb/scfd_tb_pkg.sv
tb/tb_serial_command_frame_decoder_core.sv
